// ===== sv/mcpt_pkg.sv =====
// mcpt_pkg: word types, request and result codes, state encoding and defaults
// for the multi-channel periodic timer; no dependencies
`default_nettype none

package mcpt_pkg;

	localparam int NUM_TIMERS_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [4:0] MAX_TIMERS_RST = 5'd16;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_REJECTED = 3'd1;
	localparam logic [2:0] KIND_EXPIRED  = 3'd2;
	localparam logic [2:0] KIND_NONE     = 3'd3;
	localparam logic [2:0] KIND_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] interval;
	} req_word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] timer_number;
		logic       last_of_run;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== sv/mcpt_slot_ram.sv =====
// mcpt_slot_ram: one write port, one read port, registered read data
// holds period and elapsed count of each timer slot; no dependencies
`default_nettype none

module mcpt_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/multi_channel_periodic_timer.sv =====
// multi_channel_periodic_timer: top level, request decode, tick sequencer,
// result register; depends on mcpt_pkg and mcpt_slot_ram
//
// usage
// - request channel (req_valid/req_ready/req) takes one word: tick, add or clear
// - result channel (rsp_valid/rsp_ready/rsp) gives one or more words per request;
//   the final word of each request has last_of_run set, request code 3 gives none
// - cfg_we/cfg_data write max_timers at any edge; write only while idle
// - add and clear: the result is registered and appears in the cycle after acceptance; a new
//   request is taken in the next cycle when the result is taken or the result slot is free
// - tick: the slot ram is read one timer per cycle unless stalled, newest id first, and
//   each read word is updated from the read register and written back; the one ram
//   port pair and the single incrementer/comparator are shared by all slots
// - expiries are held one deep so the newest pending one can be marked last in
//   the finishing cycle; a tick with no expiry gives a single none word
// - a stalled receiver holds the sequencer when a second expiry needs the result
//   register and holds the finishing word; ready is low for the whole tick
// - reset: no live timers, max_timers = 16, result register empty; the slot ram
//   is not cleared, entries are written by add before they are ever read
`default_nettype none

module multi_channel_periodic_timer
	import mcpt_pkg::*;
#(
	parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp,
	input  wire logic      cfg_we,
	input  wire logic [4:0] cfg_data
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int MEM_W = 2 * COUNT_WIDTH;

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] live_q, live_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic             pend_valid_q, pend_valid_d;
	logic [4:0]       pend_id_q, pend_id_d;
	logic [4:0]       max_timers_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	// ram ports
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [MEM_W-1:0] wr_data, rd_data;

	// datapath
	logic                   rsp_busy, acc, rsp_load, stall;
	rsp_word_t              rsp_next;
	logic [31:0]            ivl_w, live_w, slot_w, add_id_w, exp_id_w, live_m1_w;
	logic [COUNT_WIDTH-1:0] ivl_cw, rd_period, rd_elapsed, elapsed_inc;
	logic                   expired, add_reject;

	mcpt_slot_ram #(
		.DEPTH (NUM_TIMERS),
		.WIDTH (MEM_W),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// result register is full and not drained this cycle
	assign rsp_busy  = rsp_valid_q && !rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && !rsp_busy;
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// interval masked or zero-extended to the counter width
	assign ivl_w  = 32'(req.interval);
	assign ivl_cw = ivl_w[COUNT_WIDTH-1:0];

	assign live_w    = 32'(live_q);
	assign live_m1_w = live_w - 32'd1;
	assign slot_w    = 32'(slot_q);
	assign add_id_w  = live_w + 32'd1;
	assign exp_id_w  = slot_w + 32'd1;

	// shared incrementer and compare for the slot in the read register
	assign rd_period   = rd_data[MEM_W-1:COUNT_WIDTH];
	assign rd_elapsed  = rd_data[COUNT_WIDTH-1:0];
	assign elapsed_inc = rd_elapsed + COUNT_WIDTH'(1);
	assign expired     = elapsed_inc >= rd_period;

	// zero interval, configured limit reached, or table full
	assign add_reject = (ivl_cw == '0) || (live_w >= 32'(max_timers_q))
		|| (live_w >= 32'(NUM_TIMERS));

	// a second expiry must push the pending one out through a full register
	assign stall = (state_q == ST_TICK) && expired && pend_valid_q && rsp_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		live_d       = live_q;
		slot_d       = slot_q;
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		rsp_load     = 1'b0;
		rsp_next     = '0;
		rd_en        = 1'b0;
		rd_addr      = slot_q - IDX_W'(1);
		wr_en        = 1'b0;
		wr_addr      = slot_q;
		wr_data      = {rd_period, expired ? '0 : elapsed_inc};
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					priority case (req.req_type)
						REQ_TICK: begin
							pend_valid_d = 1'b0;
							if (live_q == '0) begin
								state_d = ST_FINISH;
							end else begin
								// newest slot first
								rd_en   = 1'b1;
								rd_addr = live_m1_w[IDX_W-1:0];
								slot_d  = live_m1_w[IDX_W-1:0];
								state_d = ST_TICK;
							end
						end
						REQ_ADD: begin
							rsp_load = 1'b1;
							if (add_reject) begin
								rsp_next = '{kind: KIND_REJECTED, timer_number: 5'd0,
									last_of_run: 1'b1};
							end else begin
								wr_en    = 1'b1;
								wr_addr  = live_w[IDX_W-1:0];
								wr_data  = {ivl_cw, {COUNT_WIDTH{1'b0}}};
								live_d   = add_id_w[CNT_W-1:0];
								rsp_next = '{kind: KIND_ADDED, timer_number: add_id_w[4:0],
									last_of_run: 1'b1};
							end
						end
						REQ_CLEAR: begin
							live_d   = '0;
							rsp_load = 1'b1;
							rsp_next = '{kind: KIND_CLEARED, timer_number: 5'd0,
								last_of_run: 1'b1};
						end
						default: begin
							// unused request code, no result
						end
					endcase
				end
			end
			ST_TICK: begin
				if (!stall) begin
					wr_en = 1'b1;
					if (expired) begin
						pend_valid_d = 1'b1;
						pend_id_d    = exp_id_w[4:0];
						if (pend_valid_q) begin
							rsp_load = 1'b1;
							rsp_next = '{kind: KIND_EXPIRED, timer_number: pend_id_q,
								last_of_run: 1'b0};
						end
					end
					if (slot_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						rd_en  = 1'b1;
						slot_d = slot_q - IDX_W'(1);
					end
				end
			end
			ST_FINISH: begin
				if (!rsp_busy) begin
					rsp_load = 1'b1;
					if (pend_valid_q) begin
						rsp_next = '{kind: KIND_EXPIRED, timer_number: pend_id_q,
							last_of_run: 1'b1};
					end else begin
						rsp_next = '{kind: KIND_NONE, timer_number: 5'd0,
							last_of_run: 1'b1};
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			pend_valid_q <= 1'b0;
			max_timers_q <= MAX_TIMERS_RST;
			rsp_valid_q  <= 1'b0;
		end else begin
			live_q       <= live_d;
			pend_valid_q <= pend_valid_d;
			if (cfg_we) begin
				max_timers_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and sequencer index, no reset needed
	always_ff @(posedge clk) begin
		slot_q    <= slot_d;
		pend_id_q <= pend_id_d;
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	// a word is never loaded over one that the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> !rsp_busy)
		else $error("result register overwritten while stalled");

	// the live count never passes the table depth
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) <= 32'(NUM_TIMERS))
		else $error("live count beyond table depth");

	// a stalled tick keeps its slot and pending expiry
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> ($stable(slot_q) && pend_valid_q && state_q == ST_TICK))
		else $error("tick advanced during stall");

	// the finishing word always ends the tick
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !rsp_busy) |=> (state_q == ST_IDLE && rsp_valid_q
		&& rsp_q.last_of_run))
		else $error("tick did not finish with a last word");

	// no ram write while a tick waits on the receiver
	a_no_write_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !wr_en)
		else $error("slot written during stall");

endmodule

`default_nettype wire
